// ===== src/tri_ang_pkg.sv =====
// ----------------------------------------------------------------------------
// tri_ang_pkg
// shared widths, cordic angle table and helpers for the triangle angle block
// ----------------------------------------------------------------------------
`default_nettype none
package tri_ang_pkg;

    localparam int COORD_BITS      = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int ANGLE_BITS      = 16;
    localparam int ITERS           = 28;
    // cordic word: products fit in 2*COORD_BITS+3, normalised to 2^48..2^49
    localparam int DIFF_BITS       = COORD_BITS + 1;
    localparam int PROD_BITS       = 2 * DIFF_BITS + 1;
    localparam int NORM_TOP        = 48;
    localparam int CW              = NORM_TOP + 4;
    localparam int ZW              = 34;
    localparam int SH_BITS         = 6;
    localparam logic signed [ZW-1:0] DEG90  = ZW'(64'sd90 <<< 24);
    localparam logic signed [ZW-1:0] DEG180 = ZW'(64'sd180 <<< 24);

    typedef logic signed [DIFF_BITS-1:0] t_diff;
    typedef logic signed [PROD_BITS-1:0] t_prod;
    typedef logic signed [CW-1:0]        t_cw;
    typedef logic signed [ZW-1:0]        t_z;

    // one cordic lane between stages
    typedef struct packed {
        t_cw x;
        t_cw y;
        t_z  z;
        logic zero;
    } t_lane;

    function automatic t_z atan_tab(input int i);
        logic [31:0] v;
        case (i)
            0: v = 754974720;  1: v = 445687602;  2: v = 235489088;
            3: v = 119537938;  4: v = 60000934;   5: v = 30029717;
            6: v = 15018523;   7: v = 7509720;    8: v = 3754917;
            9: v = 1877466;    10: v = 938734;    11: v = 469367;
            12: v = 234684;    13: v = 117342;    14: v = 58671;
            15: v = 29335;     16: v = 14668;     17: v = 7334;
            18: v = 3667;      19: v = 1833;      20: v = 917;
            21: v = 458;       22: v = 229;       23: v = 115;
            24: v = 57;        25: v = 29;        26: v = 14;
            27: v = 7;
            default: v = '0;
        endcase
        return t_z'(v);
    endfunction

endpackage
`default_nettype wire

// ===== src/tri_ang_vec.sv =====
// ----------------------------------------------------------------------------
// tri_ang_vec
// one vertex: dot/cross products, normalise, fold into cordic start word
// ----------------------------------------------------------------------------
`default_nettype none
module tri_ang_vec
    import tri_ang_pkg::*;
(
    input  wire logic  i_clk,
    input  wire t_diff i_ux,
    input  wire t_diff i_uy,
    input  wire t_diff i_vx,
    input  wire t_diff i_vy,
    output t_lane      o_lane
);
    t_prod r_p0, r_p1, r_p2, r_p3;
    logic signed [PROD_BITS:0] r_dot, r_cr;
    logic [PROD_BITS:0] r_mag;
    logic [SH_BITS-1:0] n_sh, r_sh;
    logic signed [PROD_BITS:0] r_dot2, r_cr2;
    logic r_zero;
    logic signed [PROD_BITS:0] n_dot, n_cr;
    logic [PROD_BITS:0] n_abs_d, n_abs_c;
    logic signed [CW-1:0] n_dn, n_cn;
    t_lane r_lane;

    // stage 1: four products
    always_ff @(posedge i_clk) begin
        r_p0 <= PROD_BITS'(i_ux * i_vx);
        r_p1 <= PROD_BITS'(i_uy * i_vy);
        r_p2 <= PROD_BITS'(i_ux * i_vy);
        r_p3 <= PROD_BITS'(i_uy * i_vx);
    end

    // stage 2: dot, absolute cross, magnitude
    always_comb begin
        n_dot   = (PROD_BITS+1)'(r_p0) + (PROD_BITS+1)'(r_p1);
        n_cr    = (PROD_BITS+1)'(r_p2) - (PROD_BITS+1)'(r_p3);
        n_cr    = n_cr[PROD_BITS] ? -n_cr : n_cr;
        n_abs_d = n_dot[PROD_BITS] ? $unsigned(-n_dot) : $unsigned(n_dot);
        n_abs_c = $unsigned(n_cr);
    end

    always_ff @(posedge i_clk) begin
        r_dot <= n_dot;
        r_cr  <= n_cr;
        r_mag <= (n_abs_c > n_abs_d) ? n_abs_c : n_abs_d;
    end

    // stage 3: leading one search gives normalising shift
    always_comb begin
        n_sh = '0;
        for (int k = 0; k <= PROD_BITS; k++) begin
            if (r_mag[k]) n_sh = SH_BITS'(NORM_TOP - k);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh   <= n_sh;
        r_dot2 <= r_dot;
        r_cr2  <= r_cr;
        r_zero <= (r_mag == '0);
    end

    // stage 4: shift and fold into right half plane
    always_comb begin
        n_dn = CW'(r_dot2) <<< r_sh;
        n_cn = CW'(r_cr2) <<< r_sh;
    end

    always_ff @(posedge i_clk) begin
        r_lane.zero <= r_zero;
        if (!n_dn[CW-1]) begin
            r_lane.x <= n_dn;
            r_lane.y <= n_cn;
            r_lane.z <= '0;
        end else begin
            r_lane.x <= n_cn;
            r_lane.y <= -n_dn;
            r_lane.z <= DEG90;
        end
    end

    assign o_lane = r_lane;
endmodule
`default_nettype wire

// ===== src/tri_ang_cordic.sv =====
// ----------------------------------------------------------------------------
// tri_ang_cordic
// vectoring cordic, one registered stage per step, then clamp and round
// ----------------------------------------------------------------------------
`default_nettype none
module tri_ang_cordic
    import tri_ang_pkg::*;
(
    input  wire logic   i_clk,
    input  wire t_lane  i_lane,
    output logic [ANGLE_BITS-1:0] o_angle
);
    t_lane r_st [1:ITERS];
    t_z    n_zc;
    logic [ANGLE_BITS-1:0] r_angle;

    // rotation steps
    for (genvar g = 0; g < ITERS; g++) begin : g_step
        t_lane w_in;
        t_lane n_out;

        if (g == 0) begin : g_src
            assign w_in = i_lane;
        end else begin : g_src
            assign w_in = r_st[g];
        end

        always_comb begin
            n_out.zero = w_in.zero;
            if (w_in.y > 0) begin
                n_out.x = w_in.x + (w_in.y >>> g);
                n_out.y = w_in.y - (w_in.x >>> g);
                n_out.z = w_in.z + atan_tab(g);
            end else begin
                n_out.x = w_in.x - (w_in.y >>> g);
                n_out.y = w_in.y + (w_in.x >>> g);
                n_out.z = w_in.z - atan_tab(g);
            end
        end
        always_ff @(posedge i_clk) r_st[g+1] <= n_out;
    end

    // clamp and round to output units
    always_comb begin
        n_zc = r_st[ITERS].z;
        if (n_zc < 0) n_zc = '0;
        if (n_zc > DEG180) n_zc = DEG180;
        n_zc = n_zc + (t_z'(1) <<< (23 - ANGLE_FRAC_BITS));
    end

    always_ff @(posedge i_clk) begin
        r_angle <= r_st[ITERS].zero ? '0
                 : ANGLE_BITS'(n_zc >>> (24 - ANGLE_FRAC_BITS));
    end

    assign o_angle = r_angle;
endmodule
`default_nettype wire

// ===== src/triangle_angles_from_vertices.sv =====
// ----------------------------------------------------------------------------
// triangle_angles_from_vertices
// interior angles of a triangle from its three vertices
// ----------------------------------------------------------------------------
// A word of six signed coordinates is taken at each edge with start high
// and busy low; busy is always low, so a new word may enter every cycle.
// Each vertex angle runs in its own lane: four stages of products,
// normalisation and folding, 28 cordic stages and one rounding stage.
// Each result is shown for one cycle, marked by o_valid; the receiver
// cannot stall. Throughput is one word per cycle, set by the fully
// pipelined cordic. Coinciding vertices raise o_degenerate with all
// angles zero. Synchronous active low reset clears the valid line only;
// data stages are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
module triangle_angles_from_vertices
    import tri_ang_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire logic signed [COORD_BITS-1:0] i_ax,
    input  wire logic signed [COORD_BITS-1:0] i_ay,
    input  wire logic signed [COORD_BITS-1:0] i_bx,
    input  wire logic signed [COORD_BITS-1:0] i_by_coord,
    input  wire logic signed [COORD_BITS-1:0] i_cx,
    input  wire logic signed [COORD_BITS-1:0] i_cy,
    output logic      o_valid,
    output logic [ANGLE_BITS-1:0] o_angle_at_b,
    output logic [ANGLE_BITS-1:0] o_angle_at_c,
    output logic [ANGLE_BITS-1:0] o_angle_at_a,
    output logic      o_degenerate
);
    localparam int LAT = ITERS + 6;

    t_diff r_d [6];
    logic  r_v0;
    logic  r_deg0;
    logic [LAT-2:0] r_vpipe, r_dpipe;
    t_lane w_lb, w_lc, w_la;
    logic [ANGLE_BITS-1:0] w_b, w_c, w_a;

    assign busy = 1'b0;

    // input stage: edge differences and coincidence check
    always_ff @(posedge i_clk) begin
        r_d[0] <= DIFF_BITS'(i_ax) - DIFF_BITS'(i_bx);
        r_d[1] <= DIFF_BITS'(i_ay) - DIFF_BITS'(i_by_coord);
        r_d[2] <= DIFF_BITS'(i_cx) - DIFF_BITS'(i_bx);
        r_d[3] <= DIFF_BITS'(i_cy) - DIFF_BITS'(i_by_coord);
        r_d[4] <= DIFF_BITS'(i_cx) - DIFF_BITS'(i_ax);
        r_d[5] <= DIFF_BITS'(i_cy) - DIFF_BITS'(i_ay);
        r_deg0 <= (i_ax == i_bx && i_ay == i_by_coord) ||
                  (i_bx == i_cx && i_by_coord == i_cy) ||
                  (i_ax == i_cx && i_ay == i_cy);
    end

    // valid and degenerate travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_vpipe <= '0;
        end else begin
            r_v0    <= start && !busy;
            r_vpipe <= {r_vpipe[LAT-3:0], r_v0};
        end
        r_dpipe <= {r_dpipe[LAT-3:0], r_deg0};
    end

    // B: u = A-B, v = C-B ; C: u = A-C, v = B-C ; A: u = B-A, v = C-A
    tri_ang_vec u_vb (.i_clk, .i_ux(r_d[0]), .i_uy(r_d[1]),
                      .i_vx(r_d[2]), .i_vy(r_d[3]), .o_lane(w_lb));
    tri_ang_vec u_vc (.i_clk, .i_ux(-r_d[4]), .i_uy(-r_d[5]),
                      .i_vx(-r_d[2]), .i_vy(-r_d[3]), .o_lane(w_lc));
    tri_ang_vec u_va (.i_clk, .i_ux(-r_d[0]), .i_uy(-r_d[1]),
                      .i_vx(r_d[4]), .i_vy(r_d[5]), .o_lane(w_la));

    tri_ang_cordic u_cb (.i_clk, .i_lane(w_lb), .o_angle(w_b));
    tri_ang_cordic u_cc (.i_clk, .i_lane(w_lc), .o_angle(w_c));
    tri_ang_cordic u_ca (.i_clk, .i_lane(w_la), .o_angle(w_a));

    // output word
    assign o_valid      = r_vpipe[LAT-2];
    assign o_degenerate = r_dpipe[LAT-2];
    assign o_angle_at_b = o_degenerate ? '0 : w_b;
    assign o_angle_at_c = o_degenerate ? '0 : w_c;
    assign o_angle_at_a = o_degenerate ? '0 : w_a;

    a_busy_low: assert property (@(posedge i_clk) busy == 1'b0)
        else $error("busy raised");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v0 |-> ##(LAT-1) o_valid)
        else $error("valid lost in pipe");
    a_deg_zero: assert property (@(posedge i_clk)
        (o_valid && o_degenerate) |-> (o_angle_at_a == '0 && o_angle_at_b == '0))
        else $error("degenerate angles not zero");
endmodule
`default_nettype wire
